// ===== src/iqm_pkg.sv =====
// ----------------------------------------------------------------------------
// iqm_pkg: shared types and constants
// Value widths, cell control and controller states for the interquartile
// mean of positive samples.
// ----------------------------------------------------------------------------
package iqm_pkg;

  localparam int unsigned IN_W    = 32;  // signed Q16.16 sample
  localparam int unsigned VAL_W   = 31;  // positive magnitude kept in the chain
  localparam int unsigned KEPT_W  = 9;   // width of the kept_count field
  localparam int unsigned QUART_SH = 2;  // quarter of the set: shift by log2(4)

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic ins;    // insert the broadcast value into the sorted chain
    logic shift;  // move every entry one cell toward the head
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ===== src/iqm_if.sv =====
// ----------------------------------------------------------------------------
// iqm channel interfaces
// Valid/ready channels for samples in and trimmed-mean results out.
// ----------------------------------------------------------------------------
interface iqm_in_if import iqm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  value;
  logic                    last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface iqm_out_if import iqm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VAL_W-1:0]    mean;
  logic [KEPT_W-1:0]   kept_count;
  logic                empty_res;
  logic                overflow;

  modport source (output valid, mean, kept_count, empty_res, overflow, input ready);
  modport sink   (input valid, mean, kept_count, empty_res, overflow, output ready);
endinterface

// ===== src/iqm_cell.sv =====
// ----------------------------------------------------------------------------
// iqm_cell: one slot of the insertion sort chain
// Holds one kept value; on insert it takes its left neighbor, the new value
// or keeps its own; on drain it takes its right neighbor.
// ----------------------------------------------------------------------------
module iqm_cell import iqm_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  val_t      din,
  input  logic      occ,
  input  logic      prev_occ,
  input  logic      prev_gt,
  input  val_t      prev_val,
  input  val_t      next_val,
  output val_t      val,
  output logic      gt
);

  val_t val_r;
  val_t val_nxt;

  assign val = val_r;
  assign gt  = occ && (val_r > din);

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = next_val;
    end else if (ctl.ins) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt || (!occ && prev_occ)) begin
        // new value lands here: first larger entry or first free slot
        val_nxt = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== src/iqm_div.sv =====
// ----------------------------------------------------------------------------
// iqm_div: restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module iqm_div #(
  parameter int unsigned SW = 39,
  parameter int unsigned CW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [SW-1:0] quot
);

  localparam int unsigned NW = $clog2(SW + 1);

  logic [SW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0] dsr_r;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [CW:0]   rem_sh;
  logic          qbit;

  assign rem_sh = {rem_r, dvd_r[SW-1]};
  assign qbit   = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt = qbit ? CW'(rem_sh - {1'b0, dsr_r}) : rem_sh[CW-1:0];
    dvd_nxt = {dvd_r[SW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == NW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(SW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

// ===== src/interquartile_mean_of_positives.sv =====
// ----------------------------------------------------------------------------
// interquartile_mean_of_positives: trimmed mean of positive samples
// Sorts positive samples into a chain of cells, then sums the middle half
// and divides once by the number of terms.
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while a set is loading
// after the last sample: hi cells drain (hi = n - n/4, cells shifted out
// one per cycle), the divider runs, then the result is held until taken;
// an empty set gives its result the cycle after last
// no new sample is taken from the last one until the result is taken
// reset (synchronous, active low) clears the count, drop flag and controller
module interquartile_mean_of_positives import iqm_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  iqm_in_if.sink        in_ch,
  iqm_out_if.source     out_ch
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = VAL_W + $clog2(DEPTH);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [VAL_W-1:0]  mean_r, mean_nxt;
  logic [KEPT_W-1:0] kept_r, kept_nxt;
  logic          empty_r, empty_nxt;
  logic          ovf_r, ovf_nxt;

  logic          accept;
  logic          pos;
  logic          ins;
  logic [CW-1:0] n_after;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [SW-1:0] sum_add;
  logic          drain_end;
  logic          div_start;
  logic          div_done;
  logic [SW-1:0] quot;
  cell_ctl_t     ctl;

  val_t          cval [DEPTH];
  logic          cgt  [DEPTH];
  logic          cocc [DEPTH];

  assign accept  = in_ch.valid && in_ch.ready;
  assign pos     = !in_ch.value[IN_W-1] && (in_ch.value != '0);
  assign ins     = accept && pos && (count_r < CW'(DEPTH));
  assign n_after = count_r + CW'(ins);

  assign lo        = count_r >> QUART_SH;
  assign hi        = count_r - lo;
  assign sum_add   = (idx_r >= lo) ? SW'(cval[0]) : '0;
  assign drain_end = (idx_r == hi - CW'(1));
  assign div_start = (state_r == S_DRAIN) && drain_end;

  assign ctl.ins   = ins;
  assign ctl.shift = (state_r == S_DRAIN);

  // sorted chain, head at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cocc[i] = (count_r > CW'(i));
    if (i == 0) begin : g_head
      iqm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .din      (in_ch.value[VAL_W-1:0]),
        .occ      (cocc[i]),
        .prev_occ (1'b1),
        .prev_gt  (1'b0),
        .prev_val (cval[i]),
        .next_val (cval[i+1]),
        .val      (cval[i]),
        .gt       (cgt[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      iqm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .din      (in_ch.value[VAL_W-1:0]),
        .occ      (cocc[i]),
        .prev_occ (cocc[i-1]),
        .prev_gt  (cgt[i-1]),
        .prev_val (cval[i-1]),
        .next_val (cval[i]),
        .val      (cval[i]),
        .gt       (cgt[i])
      );
    end else begin : g_mid
      iqm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .din      (in_ch.value[VAL_W-1:0]),
        .occ      (cocc[i]),
        .prev_occ (cocc[i-1]),
        .prev_gt  (cgt[i-1]),
        .prev_val (cval[i-1]),
        .next_val (cval[i+1]),
        .val      (cval[i]),
        .gt       (cgt[i])
      );
    end
  end

  iqm_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (hi - lo),
    .done     (div_done),
    .quot     (quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept && in_ch.last) begin
          state_nxt = (n_after == '0) ? S_OUT : S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_end) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // datapath and result registers
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    mean_nxt  = mean_r;
    kept_nxt  = kept_r;
    empty_nxt = empty_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      S_LOAD: begin
        count_nxt = n_after;
        if (accept && pos && !ins) begin
          drop_nxt = 1'b1;
        end
        idx_nxt = '0;
        sum_nxt = '0;
        if (accept && in_ch.last && n_after == '0) begin
          mean_nxt  = '0;
          kept_nxt  = '0;
          empty_nxt = 1'b1;
          ovf_nxt   = drop_r;
        end
      end
      S_DRAIN: begin
        sum_nxt = sum_r + sum_add;
        idx_nxt = idx_r + CW'(1);
      end
      S_DIV: begin
        if (div_done) begin
          mean_nxt  = quot[VAL_W-1:0];
          kept_nxt  = KEPT_W'(count_r);
          empty_nxt = 1'b0;
          ovf_nxt   = drop_r;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    sum_r   <= sum_nxt;
    mean_r  <= mean_nxt;
    kept_r  <= kept_nxt;
    empty_r <= empty_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign in_ch.ready       = (state_r == S_LOAD);
  assign out_ch.valid      = (state_r == S_OUT);
  assign out_ch.mean       = mean_r;
  assign out_ch.kept_count = kept_r;
  assign out_ch.empty_res  = empty_r;
  assign out_ch.overflow   = ovf_r;

endmodule
